// ===== sv/lfbp_pkg.sv =====
package lfbp_pkg;

  localparam int WORD_BITS   = 64;
  localparam int CNT_W       = 7;
  localparam int OFF_W       = 6;
  localparam int STORE_WORDS = 1024;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_PAST_END = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_SECOND
  } state_t;

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    if (n >= CNT_W'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = ({{(WORD_BITS-1){1'b0}}, 1'b1} << n) - {{(WORD_BITS-1){1'b0}}, 1'b1};
    end
    return m;
  endfunction

endpackage

// ===== sv/lsb_first_bit_packer_unpacker.sv =====
// LSB-first bit packer and unpacker over STORE_WORDS 64-bit words. A write request appends the
// low bit_count bits of data_value at the write cursor; a read request returns bit_count bits
// from the read cursor, right aligned. Each request gives one result with a status: ok, store
// full (write dropped) or read past end (value 0). Counts above 64 act as 64, a count of zero
// does nothing. A write is accepted while idle and gives its result from the first state; a read
// does too, or from a second state when it spans two words, as each stored word costs one access
// of the single-port word memory. The next request is taken once the result sits in the output
// register, while it waits there. The word being filled is held in a register and only complete
// words go to memory, so the block is ready straight after reset with no clearing pass.
module lsb_first_bit_packer_unpacker #(
  parameter int STORE_WORDS = lfbp_pkg::STORE_WORDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [63:0] data_value,
  input  logic [6:0]  bit_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] read_value,
  output logic [1:0]  status
);

  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int RW = $clog2(STORE_WORDS + 1);
  localparam int WB = lfbp_pkg::WORD_BITS;
  localparam int CW = lfbp_pkg::CNT_W;
  localparam int OW = lfbp_pkg::OFF_W;

  lfbp_pkg::state_t state, state_next;

  logic          req_is_rd;
  logic [WB-1:0] req_val;
  logic [CW-1:0] req_n;

  logic [AW-1:0] wr_idx, wr_idx_next;
  logic [OW-1:0] wr_off, wr_off_next;
  logic [RW-1:0] rd_idx, rd_idx_next;
  logic [OW-1:0] rd_off, rd_off_next;
  logic [WB-1:0] wr_word, wr_word_next;
  logic [WB-1:0] lo_word;
  logic          lo_load;

  logic [WB-1:0] mem [STORE_WORDS];
  logic [WB-1:0] mem_q;
  logic          mem_en, mem_we;
  logic [AW-1:0] mem_addr;
  logic [WB-1:0] mem_wdata;

  logic               commit;
  logic [WB-1:0]      res_val;
  lfbp_pkg::status_t  res_st;
  logic               slot_free;

  logic [RW-1:0]   wi_ext, rd_idx_inc;
  logic [CW-1:0]   rd_end, wr_end;
  logic            rd_split;
  logic [WB-1:0]   word_a, word_b;
  logic [2*WB-1:0] rd_pair, rd_shift, wr_wide;
  logic [WB-1:0]   rd_data, wr_vm, wr_merged;

  assign slot_free  = !out_valid || out_ready;
  assign wi_ext     = RW'(wr_idx);
  assign rd_idx_inc = rd_idx + RW'(1);
  assign rd_end     = CW'(rd_off) + req_n;
  assign wr_end     = CW'(wr_off) + req_n;
  assign rd_split   = rd_end > CW'(WB);
  assign word_a     = (rd_idx == wi_ext) ? wr_word : mem_q;
  assign word_b     = (rd_idx_inc == wi_ext) ? wr_word : mem_q;
  assign rd_pair    = (state == lfbp_pkg::S_SECOND) ? {word_b, lo_word} : {{WB{1'b0}}, word_a};
  assign rd_shift   = rd_pair >> rd_off;
  assign rd_data    = rd_shift[WB-1:0] & lfbp_pkg::low_mask(req_n);
  assign wr_vm      = req_val & lfbp_pkg::low_mask(req_n);
  assign wr_wide    = {{WB{1'b0}}, wr_vm} << wr_off;
  assign wr_merged  = wr_word | wr_wide[WB-1:0];

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    mem_en       = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = rd_idx[AW-1:0];
    mem_wdata    = wr_merged;
    commit       = 1'b0;
    res_val      = '0;
    res_st       = lfbp_pkg::ST_OK;
    lo_load      = 1'b0;
    wr_idx_next  = wr_idx;
    wr_off_next  = wr_off;
    rd_idx_next  = rd_idx;
    rd_off_next  = rd_off;
    wr_word_next = wr_word;
    case (state)
      lfbp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mem_en     = rd_idx < wi_ext;
          state_next = lfbp_pkg::S_FIRST;
        end
      end
      lfbp_pkg::S_FIRST: begin
        if (req_n == '0) begin
          commit = slot_free;
        end else if (!req_is_rd) begin
          if (wr_end < CW'(WB)) begin
            commit = slot_free;
            if (slot_free) begin
              wr_word_next = wr_merged;
              wr_off_next  = wr_end[OW-1:0];
            end
          end else if (wr_idx == AW'(STORE_WORDS - 1)) begin
            res_st = lfbp_pkg::ST_FULL;
            commit = slot_free;
          end else begin
            commit = slot_free;
            if (slot_free) begin
              mem_en       = 1'b1;
              mem_we       = 1'b1;
              mem_addr     = wr_idx;
              wr_word_next = wr_wide[2*WB-1:WB];
              wr_idx_next  = wr_idx + AW'(1);
              wr_off_next  = wr_end[OW-1:0];
            end
          end
        end else if (!rd_split) begin
          if (rd_idx > wi_ext) begin
            res_st = lfbp_pkg::ST_PAST_END;
            commit = slot_free;
          end else begin
            res_val = rd_data;
            commit  = slot_free;
            if (slot_free) begin
              if (rd_end == CW'(WB)) begin
                rd_idx_next = rd_idx_inc;
                rd_off_next = '0;
              end else begin
                rd_off_next = rd_end[OW-1:0];
              end
            end
          end
        end else if (rd_idx >= wi_ext) begin
          res_st = lfbp_pkg::ST_PAST_END;
          commit = slot_free;
        end else begin
          mem_en     = rd_idx_inc < wi_ext;
          mem_addr   = rd_idx_inc[AW-1:0];
          lo_load    = 1'b1;
          state_next = lfbp_pkg::S_SECOND;
        end
        if (commit) begin
          state_next = lfbp_pkg::S_IDLE;
        end
      end
      lfbp_pkg::S_SECOND: begin
        res_val = rd_data;
        commit  = slot_free;
        if (slot_free) begin
          rd_idx_next = rd_idx_inc;
          rd_off_next = rd_end[OW-1:0];
          state_next  = lfbp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lfbp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfbp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx  <= '0;
      wr_off  <= '0;
      rd_idx  <= '0;
      rd_off  <= '0;
      wr_word <= '0;
    end else begin
      wr_idx  <= wr_idx_next;
      wr_off  <= wr_off_next;
      rd_idx  <= rd_idx_next;
      rd_off  <= rd_off_next;
      wr_word <= wr_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_is_rd <= req_type;
      req_val   <= data_value;
      req_n     <= (bit_count > CW'(WB)) ? CW'(WB) : bit_count;
    end
    if (lo_load) begin
      lo_word <= word_a;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_en) begin
      if (mem_we) begin
        mem[mem_addr] <= mem_wdata;
      end else begin
        mem_q <= mem[mem_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      read_value <= res_val;
      status     <= res_st;
    end
  end

endmodule
